/* hdl/ttb_pkg.sv */
package ttb_pkg;

   // field widths fixed by the interface
   localparam int CMD_W     = 3;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 16;
   localparam int CFG_W     = 4;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   typedef logic [1:0]         mode_type;
   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [3:0]         digit_type;

   // timer modes
   localparam mode_type MODE_CLOSED  = 2'd0;
   localparam mode_type MODE_RUNNING = 2'd1;
   localparam mode_type MODE_ENDED   = 2'd2;

   // commands; unknown codes act as a query
   localparam cmd_type CMD_TICK    = 3'd0;
   localparam cmd_type CMD_START   = 3'd1;
   localparam cmd_type CMD_RESTART = 3'd2;
   localparam cmd_type CMD_CLOSE   = 3'd3;
   localparam cmd_type CMD_QUERY   = 3'd4;

   // register word indexes
   localparam logic [PADDR_W-3:0] REG_TIMERS_IN_USE = 1'd0;
   localparam logic [CFG_W-1:0]   TIMERS_IN_USE_RST = 4'd8;

   // prescaler kept as two decimal digits
   localparam int        TENS_STEP  = 10;
   localparam digit_type DIGIT_LAST = 4'(TENS_STEP - 1);

   // one stored timer entry
   typedef struct packed {
      mode_type  mode;
      count_type count;
   } entry_type;

   // one result word
   typedef struct packed {
      mode_type  mode;
      logic      is_running;
      count_type count;
      logic      tick_seen;
      logic      tens_reached;
      logic      hundred_reached;
   } rsp_type;

   // one tick applied to one entry
   function automatic entry_type tick_entry(entry_type e);
      entry_type r;
      r = e;
      if (e.mode == MODE_RUNNING) begin
         if (e.count != '0) begin
            r.count = e.count - 16'd1;
         end else begin
            r.mode = MODE_ENDED;
         end
      end
      return r;
   endfunction

endpackage

/* hdl/ttb_ram.sv */
module ttb_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/tick_timer_bank.sv */
// tick_timer_bank: a bank of one-shot countdown timers held in one RAM.
// The request channel (req_*) carries a command word: tick, start (only if
// the timer is closed), restart, close or query, with a timer index and a
// load value. Each request gives one response word (rsp_*) with the
// addressed timer's mode and count, or for a tick the prescaler pulses.
// The register timers_in_use (byte address 0 on the APB port) limits the
// entries in use; indices at or above it change nothing and read as zero.
// A tick sweeps the entries in use through the RAM, one read and one
// write-back per cycle, overlapped; any other command reads and writes
// back only the addressed entry, and an index out of range goes straight
// to its response without touching the RAM.
// One request is worked on at a time; req_ready is high while the block
// is free, also while an earlier response still waits to be taken.
// If the receiver stalls, the finished response waits in its output
// register and the next request completes into a holding register, so
// at most one further request is accepted until the receiver takes one.
// Reset (synchronous) marks every entry closed with count zero through
// per-entry valid bits, clears the prescaler and sets timers_in_use to 8.
module tick_timer_bank #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ttb_pkg::cmd_type             req_cmd,
   input  logic [ttb_pkg::INDEX_W-1:0]  req_timer_index,
   input  ttb_pkg::count_type           req_load_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ttb_pkg::mode_type            rsp_timer_mode_out,
   output logic                         rsp_is_running,
   output ttb_pkg::count_type           rsp_count_out,
   output logic                         rsp_tick_seen,
   output logic                         rsp_tens_reached,
   output logic                         rsp_hundred_reached,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ttb_pkg::PADDR_W-1:0]  paddr,
   input  logic [ttb_pkg::PDATA_W-1:0]  pwdata,
   output logic [ttb_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   import ttb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int CMP_W = (LIM_W > INDEX_W) ? LIM_W : INDEX_W;
   localparam int ENT_W = $bits(entry_type);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SWEEP  = 2'd1;
   localparam logic [1:0] S_ACCESS = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]            state_ff,    state_in;
   cmd_type               cmd_ff,      cmd_in;
   count_type             load_ff,     load_in;
   logic [LIM_W-1:0]      rd_cnt_ff,   rd_cnt_in;
   logic                  wb_pend_ff,  wb_pend_in;
   logic [IDX_W-1:0]      wb_addr_ff,  wb_addr_in;
   logic [NUM_TIMERS-1:0] valid_ff,    valid_in;
   digit_type             units_ff,    units_in;
   digit_type             tens_ff,     tens_in;
   logic [CFG_W-1:0]      timers_ff,   timers_in;
   rsp_type               res_ff,      res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff,      rsp_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   entry_type             ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENT_W-1:0]      ram_rdata;

   logic [LIM_W-1:0]      lim;
   logic [LIM_W-1:0]      cfg_lim;
   logic                  in_range;
   entry_type             cur;
   entry_type             upd;
   logic                  cfg_write;

   // entry store
   ttb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_TIMERS),
      .AW    (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // effective limit, saturated to the bank size
   assign cfg_lim  = LIM_W'(timers_ff);
   assign lim      = (cfg_lim > LIM_W'(NUM_TIMERS)) ? LIM_W'(NUM_TIMERS) : cfg_lim;
   assign in_range = CMP_W'(req_timer_index) < CMP_W'(lim);

   // read data, an entry never written reads as closed with count zero
   assign cur = valid_ff[wb_addr_ff] ? entry_type'(ram_rdata) : '0;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite &&
                      (paddr[PADDR_W-1:2] == REG_TIMERS_IN_USE);
   assign prdata    = (paddr[PADDR_W-1:2] == REG_TIMERS_IN_USE) ?
                      PDATA_W'(timers_ff) : '0;

   always_comb begin
      timers_in = timers_ff;
      if (cfg_write) begin
         timers_in = pwdata[CFG_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      load_in      = load_ff;
      rd_cnt_in    = rd_cnt_ff;
      wb_pend_in   = wb_pend_ff;
      wb_addr_in   = wb_addr_ff;
      valid_in     = valid_ff;
      units_in     = units_ff;
      tens_in      = tens_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = wb_addr_ff;
      ram_raddr    = rd_cnt_ff[IDX_W-1:0];
      upd          = tick_entry(cur);
      req_ready    = (state_ff == S_IDLE);

      // response register drains on its own handshake
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               load_in = req_load_value;
               res_in  = '0;
               if (req_cmd == CMD_TICK) begin
                  // prescaler as two decimal digits
                  res_in.tick_seen = 1'b1;
                  if (units_ff == DIGIT_LAST) begin
                     units_in            = '0;
                     res_in.tens_reached = 1'b1;
                     if (tens_ff == DIGIT_LAST) begin
                        tens_in                = '0;
                        res_in.hundred_reached = 1'b1;
                     end else begin
                        tens_in = tens_ff + 4'd1;
                     end
                  end else begin
                     units_in = units_ff + 4'd1;
                  end
                  rd_cnt_in  = '0;
                  wb_pend_in = 1'b0;
                  state_in   = S_SWEEP;
               end else if (in_range) begin
                  ram_raddr  = req_timer_index[IDX_W-1:0];
                  wb_addr_in = req_timer_index[IDX_W-1:0];
                  state_in   = S_ACCESS;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_SWEEP: begin
            // write back the entry read last cycle
            if (wb_pend_ff) begin
               ram_we               = 1'b1;
               valid_in[wb_addr_ff] = 1'b1;
            end
            // read the next entry in use
            if (rd_cnt_ff != lim) begin
               ram_raddr  = rd_cnt_ff[IDX_W-1:0];
               wb_addr_in = rd_cnt_ff[IDX_W-1:0];
               wb_pend_in = 1'b1;
               rd_cnt_in  = rd_cnt_ff + LIM_W'(1);
            end else begin
               wb_pend_in = 1'b0;
               state_in   = S_DONE;
            end
         end

         S_ACCESS: begin
            upd = cur;
            unique case (cmd_ff)
               CMD_START: begin
                  if (cur.mode == MODE_CLOSED) begin
                     upd.mode  = MODE_RUNNING;
                     upd.count = load_ff;
                  end
               end
               CMD_RESTART: begin
                  upd.mode  = MODE_RUNNING;
                  upd.count = load_ff;
               end
               CMD_CLOSE: begin
                  upd.mode = MODE_CLOSED;
               end
               default: begin
                  upd = cur;
               end
            endcase
            ram_we               = 1'b1;
            valid_in[wb_addr_ff] = 1'b1;
            res_in               = '0;
            res_in.mode          = upd.mode;
            res_in.is_running    = (upd.mode == MODE_RUNNING);
            res_in.count         = upd.count;
            state_in             = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      ram_wdata = upd;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         wb_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         units_ff     <= '0;
         tens_ff      <= '0;
         timers_ff    <= TIMERS_IN_USE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         wb_pend_ff   <= wb_pend_in;
         valid_ff     <= valid_in;
         units_ff     <= units_in;
         tens_ff      <= tens_in;
         timers_ff    <= timers_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      load_ff    <= load_in;
      wb_addr_ff <= wb_addr_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // response ports
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_timer_mode_out  = rsp_ff.mode;
   assign rsp_is_running      = rsp_ff.is_running;
   assign rsp_count_out       = rsp_ff.count;
   assign rsp_tick_seen       = rsp_ff.tick_seen;
   assign rsp_tens_reached    = rsp_ff.tens_reached;
   assign rsp_hundred_reached = rsp_ff.hundred_reached;

   // checks
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SWEEP || state_ff == S_ACCESS))
      else $error("entry write outside sweep or access");

   a_running_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_running == (rsp_ff.mode == MODE_RUNNING)))
      else $error("is_running disagrees with mode");

   a_tick_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tick_seen) |->
         (rsp_ff.mode == MODE_CLOSED && rsp_ff.count == '0 && !rsp_ff.is_running))
      else $error("tick word carries entry fields");

   a_hundred_tens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hundred_reached) |->
         (rsp_ff.tens_reached && rsp_ff.tick_seen))
      else $error("hundred pulse without tens pulse");

   a_digits: assert property (@(posedge clock) disable iff (reset)
      (units_ff <= DIGIT_LAST) && (tens_ff <= DIGIT_LAST))
      else $error("prescaler digit out of range");

endmodule

/* sim/tick_timer_bank_checker.sv */
`timescale 1ns / 100ps

module tick_timer_bank_checker
   import ttb_pkg::*;
#(
   parameter int NUM_TIMERS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  cmd_type             req_cmd,
   input  logic [INDEX_W-1:0]  req_timer_index,
   input  count_type           req_load_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  mode_type            rsp_timer_mode_out,
   input  logic                rsp_is_running,
   input  count_type           rsp_count_out,
   input  logic                rsp_tick_seen,
   input  logic                rsp_tens_reached,
   input  logic                rsp_hundred_reached,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   input  logic [PDATA_W-1:0]  prdata,
   input  logic                pready,
   output int                  fail_count,
   output int                  words_pending,
   output int                  words_checked
);

   localparam int PRESCALE_WRAP = 100;
   localparam int SLOT_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // shadow copy of the timer bank
   mode_type         timer_mode [NUM_TIMERS];
   count_type        timer_count [NUM_TIMERS];
   logic [6:0]       tick_prescale;
   logic [CFG_W-1:0] timers_in_use;
   rsp_type          expected_words [$];

   initial begin
      fail_count    = 0;
      words_pending = 0;
      words_checked = 0;
   end

   // apply one command to the shadow bank and return the word it should give
   function automatic rsp_type timer_bank_update(cmd_type cmd, logic [INDEX_W-1:0] idx,
                                                 count_type load);
      rsp_type           w;
      int unsigned       lim;
      int unsigned       i;
      logic [SLOT_W-1:0] slot;
      w   = '0;
      lim = (timers_in_use > NUM_TIMERS) ? NUM_TIMERS : timers_in_use;
      if (cmd == CMD_TICK) begin
         for (i = 0; i < lim; i++) begin
            if (timer_mode[i] == MODE_RUNNING) begin
               if (timer_count[i] != '0) begin
                  timer_count[i] = timer_count[i] - 16'd1;
               end else begin
                  timer_mode[i] = MODE_ENDED;
               end
            end
         end
         tick_prescale = tick_prescale + 7'd1;
         w.tick_seen   = 1'b1;
         if ((tick_prescale % TENS_STEP) == 0) begin
            w.tens_reached = 1'b1;
            if (tick_prescale >= PRESCALE_WRAP) begin
               tick_prescale     = '0;
               w.hundred_reached = 1'b1;
            end
         end
         return w;
      end
      // out of range indices change nothing and read as zero
      if (idx >= lim) begin
         return w;
      end
      slot = idx[SLOT_W-1:0];
      case (cmd)
         CMD_START: begin
            if (timer_mode[slot] == MODE_CLOSED) begin
               timer_mode[slot]  = MODE_RUNNING;
               timer_count[slot] = load;
            end
         end
         CMD_RESTART: begin
            timer_mode[slot]  = MODE_RUNNING;
            timer_count[slot] = load;
         end
         CMD_CLOSE: begin
            timer_mode[slot] = MODE_CLOSED;
         end
         default: begin
         end
      endcase
      w.mode       = timer_mode[slot];
      w.is_running = (timer_mode[slot] == MODE_RUNNING);
      w.count      = timer_count[slot];
      return w;
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // watch both channels and the register port on every rising edge
   always @(posedge clock) begin
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < NUM_TIMERS; i++) begin
            timer_mode[i]  = MODE_CLOSED;
            timer_count[i] = '0;
         end
         tick_prescale = '0;
         timers_in_use = TIMERS_IN_USE_RST;
         expected_words.delete();
      end else begin
         // register writes and read-back
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[PADDR_W-1:2] == REG_TIMERS_IN_USE) begin
                  timers_in_use = pwdata[CFG_W-1:0];
               end
            end else if (paddr[PADDR_W-1:2] == REG_TIMERS_IN_USE &&
                         prdata !== PDATA_W'(timers_in_use)) begin
               $error("timers_in_use read: expected %0d, got %0d", timers_in_use, prdata);
               fail_count++;
            end
         end
         // response word against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("timer_mode_out", 16'(want.mode), 16'(rsp_timer_mode_out));
               check_field("is_running", 16'(want.is_running), 16'(rsp_is_running));
               check_field("count_out", want.count, rsp_count_out);
               check_field("tick_seen", 16'(want.tick_seen), 16'(rsp_tick_seen));
               check_field("tens_reached", 16'(want.tens_reached),
                           16'(rsp_tens_reached));
               check_field("hundred_reached", 16'(want.hundred_reached),
                           16'(rsp_hundred_reached));
               words_checked++;
            end
         end
         // request word
         if (req_valid && req_ready) begin
            expected_words.push_back(timer_bank_update(req_cmd, req_timer_index,
                                                       req_load_value));
         end
      end
      words_pending = expected_words.size();
   end

endmodule

/* sim/tb_tick_timer_bank.sv */
`timescale 1ns / 100ps

module tb_tick_timer_bank;
   import ttb_pkg::*;

   localparam int      NUM_TIMERS     = 8;
   localparam int      HALF_PERIOD    = 6;
   localparam int      RESET_CYCLES   = 6;
   localparam int      SETTLE_CYCLES  = NUM_TIMERS + 3;
   localparam int      STALL_CYCLES   = 300;
   localparam int      WATCHDOG_LIMIT = 2000;
   localparam int      PHASE_WORDS    = 150;
   localparam int      PHASES         = 9;
   localparam cmd_type CMD_LAST       = '1;
   localparam logic [PADDR_W-1:0] ADDR_TIMERS_IN_USE = {REG_TIMERS_IN_USE, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_SPARE_REG     = {~REG_TIMERS_IN_USE, 2'b00};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   cmd_type             req_cmd = CMD_TICK;
   logic [INDEX_W-1:0]  req_timer_index = '0;
   count_type           req_load_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   mode_type            rsp_timer_mode_out;
   logic                rsp_is_running;
   count_type           rsp_count_out;
   logic                rsp_tick_seen;
   logic                rsp_tens_reached;
   logic                rsp_hundred_reached;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int   fail_count;
   int   words_pending;
   int   words_checked;
   int   idle_cycles = 0;
   int   words_sent = 0;
   int   ticks_sent = 0;
   int   limits_tried = 0;
   int   current_limit = TIMERS_IN_USE_RST;
   bit   req_steady = 1'b0;
   bit   rsp_steady = 1'b0;
   bit   rsp_hold_request = 1'b0;

   tick_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_timer_index    (req_timer_index),
      .req_load_value     (req_load_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_timer_mode_out (rsp_timer_mode_out),
      .rsp_is_running     (rsp_is_running),
      .rsp_count_out      (rsp_count_out),
      .rsp_tick_seen      (rsp_tick_seen),
      .rsp_tens_reached   (rsp_tens_reached),
      .rsp_hundred_reached(rsp_hundred_reached),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   tick_timer_bank_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_timer_index    (req_timer_index),
      .req_load_value     (req_load_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_timer_mode_out (rsp_timer_mode_out),
      .rsp_is_running     (rsp_is_running),
      .rsp_count_out      (rsp_count_out),
      .rsp_tick_seen      (rsp_tick_seen),
      .rsp_tens_reached   (rsp_tens_reached),
      .rsp_hundred_reached(rsp_hundred_reached),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .words_pending      (words_pending),
      .words_checked      (words_checked)
   );

   // clock
   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random ready pattern, one long hold-off on request
   initial begin
      int run;
      int gap;
      wait (!reset);
      forever begin
         if (rsp_hold_request) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (STALL_CYCLES - 1) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            run = $urandom_range(1, 40);
            repeat (run) begin
               @(negedge clock);
               rsp_ready = 1'b1;
            end
            gap = rsp_steady ? 0 : pick_gap();
            repeat (gap) begin
               @(negedge clock);
               rsp_ready = 1'b0;
            end
         end
      end
   end

   // offer one request word and wait for it to be taken
   task automatic send_word(cmd_type cmd, logic [INDEX_W-1:0] idx, count_type load);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_timer_index = idx;
      req_load_value  = load;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (cmd == CMD_TICK) ticks_sent++;
   endtask

   // stop offering and let every outstanding word come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register transfer: setup cycle, then access cycle
   task automatic csr_access(logic write, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_limit(int value);
      wait_drained();
      csr_access(1'b1, ADDR_TIMERS_IN_USE, PDATA_W'(value));
      csr_access(1'b0, ADDR_TIMERS_IN_USE, '0);
      current_limit = value;
      limits_tried++;
   endtask

   // stimulus
   initial begin
      int         phase_limits [PHASES];
      int         p;
      int         n;
      int         r;
      int         in_use;
      cmd_type    cmd;
      logic [7:0] idx;
      count_type  load;

      phase_limits = '{8, 1, 0, 15, 5, 8, 2, 9, 8};

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // reset value of the limit, and a write to an unused register slot
      csr_access(1'b0, ADDR_TIMERS_IN_USE, '0);
      csr_access(1'b1, ADDR_SPARE_REG, '1);
      csr_access(1'b0, ADDR_TIMERS_IN_USE, '0);

      // directed: modes, ignored start, close keeping count, range, odd codes
      send_word(CMD_QUERY, 8'd0, 16'd0);
      send_word(CMD_START, 8'd0, 16'hFFFF);
      send_word(CMD_START, 8'd7, 16'd0);
      send_word(CMD_START, 8'd0, 16'd5);
      send_word(CMD_TICK, 8'hFF, 16'hFFFF);
      send_word(CMD_QUERY, 8'd7, 16'd0);
      send_word(CMD_START, 8'd7, 16'd3);
      send_word(CMD_RESTART, 8'd7, 16'd2);
      send_word(CMD_CLOSE, 8'd0, 16'd0);
      send_word(CMD_QUERY, 8'd0, 16'd0);
      send_word(CMD_QUERY, 8'd8, 16'd0);
      send_word(CMD_RESTART, 8'hFF, 16'hFFFF);
      send_word(cmd_type'(CMD_QUERY + 1), 8'd7, 16'd0);
      send_word(cmd_type'(CMD_QUERY + 2), 8'd7, 16'hFFFF);
      send_word(CMD_LAST, 8'd7, 16'd0);
      send_word(CMD_RESTART, 8'd3, 16'hAAAA);
      send_word(CMD_RESTART, 8'd4, 16'h5555);
      send_word(CMD_CLOSE, 8'd7, 16'd0);
      send_word(CMD_START, 8'd7, 16'd1);
      send_word(CMD_TICK, 8'd0, 16'd0);
      send_word(CMD_TICK, 8'd0, 16'd0);
      send_word(CMD_TICK, 8'd0, 16'd0);
      send_word(CMD_QUERY, 8'd7, 16'd0);

      // random phases, each under its own limit
      for (p = 0; p < PHASES; p++) begin
         set_limit(phase_limits[p]);
         in_use     = (current_limit > NUM_TIMERS) ? NUM_TIMERS : current_limit;
         rsp_steady = (p == 5);
         for (n = 0; n < PHASE_WORDS; n++) begin
            // fill the block while the receiver holds off
            if (p == 0 && n == 40) begin
               rsp_hold_request = 1'b1;
               req_steady       = 1'b1;
            end
            if (p == 0 && n == 60) req_steady = 1'b0;
            req_steady = req_steady || (p == 5);
            if ((p == 0 && n == 100) || $urandom_range(0, 99) == 0) wait_drained();

            r = $urandom_range(0, 99);
            if (r < 30) cmd = CMD_TICK;
            else if (r < 50) cmd = CMD_START;
            else if (r < 63) cmd = CMD_RESTART;
            else if (r < 73) cmd = CMD_CLOSE;
            else if (r < 92) cmd = CMD_QUERY;
            else cmd = cmd_type'($urandom_range(CMD_QUERY + 1, CMD_LAST));

            if (in_use > 0 && $urandom_range(0, 99) < 85) begin
               idx = 8'($urandom_range(0, in_use - 1));
            end else begin
               idx = 8'($urandom_range(0, 255));
            end

            r = $urandom_range(0, 99);
            if (r < 70) load = 16'($urandom_range(0, 15));
            else if (r < 90) load = 16'($urandom_range(0, 16'hFFFF));
            else if (r < 95) load = '0;
            else load = '1;

            send_word(cmd, idx, load);
         end
         req_steady = 1'b0;
      end

      wait_drained();

      $display("covered %0d request words (%0d ticks) over %0d timer limit settings",
               words_sent, ticks_sent, limits_tried + 1);
      $display("%0d response words checked, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
